// ===== src/ptf_pkg.sv =====
package ptf_pkg;

  localparam int COORD_WIDTH_DEF    = 24;
  localparam int QUAT_FRAC_BITS_DEF = 15;

  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_POINT = 2'd0,
    MODE_POSE  = 2'd1,
    MODE_LOST  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ABOVE = 2'd0,
    CFG_BELOW = 2'd1,
    CFG_FLOOR = 2'd2,
    CFG_PASS  = 2'd3
  } cfg_idx_t;

  localparam int CLR_ABOVE_RST = 6000;
  localparam int CLR_BELOW_RST = 2500;
  localparam int FLOOR_RST     = 1500;

  // quaternion product slots
  localparam int QP_XX = 0;
  localparam int QP_YY = 1;
  localparam int QP_ZZ = 2;
  localparam int QP_XY = 3;
  localparam int QP_XZ = 4;
  localparam int QP_YZ = 5;
  localparam int QP_WX = 6;
  localparam int QP_WY = 7;
  localparam int QP_WZ = 8;
  localparam int QP_N  = 9;

  typedef struct packed {
    logic load;
    logic lost;
  } pose_ctl_t;

  typedef struct packed {
    logic en2;
    logic en3;
  } xf_ctl_t;

endpackage

// ===== src/ptf_in_if.sv =====
interface ptf_in_if #(
  parameter int COORD_WIDTH    = ptf_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = ptf_pkg::QUAT_FRAC_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [ptf_pkg::MODE_W-1:0]      mode;
  logic signed [COORD_WIDTH-1:0]   point_x;
  logic signed [COORD_WIDTH-1:0]   point_y;
  logic signed [COORD_WIDTH-1:0]   point_z;
  logic                            point_finite;
  logic signed [QUAT_FRAC_BITS:0]  pose_qw;
  logic signed [QUAT_FRAC_BITS:0]  pose_qx;
  logic signed [QUAT_FRAC_BITS:0]  pose_qy;
  logic signed [QUAT_FRAC_BITS:0]  pose_qz;
  logic signed [COORD_WIDTH-1:0]   pose_tx;
  logic signed [COORD_WIDTH-1:0]   pose_ty;
  logic signed [COORD_WIDTH-1:0]   pose_tz;

  modport source (
    output valid, mode, point_x, point_y, point_z, point_finite,
           pose_qw, pose_qx, pose_qy, pose_qz, pose_tx, pose_ty, pose_tz,
    input  ready
  );

  modport sink (
    input  valid, mode, point_x, point_y, point_z, point_finite,
           pose_qw, pose_qx, pose_qy, pose_qz, pose_tx, pose_ty, pose_tz,
    output ready
  );
endinterface

// ===== src/ptf_out_if.sv =====
interface ptf_out_if #(
  parameter int COORD_WIDTH = ptf_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          raw_frame;
  logic                          out_finite;

  modport source (
    output valid, out_x, out_y, out_z, raw_frame, out_finite,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, raw_frame, out_finite,
    output ready
  );
endinterface

// ===== src/ptf_cfg_if.sv =====
interface ptf_cfg_if #(
  parameter int COORD_WIDTH = ptf_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [ptf_pkg::CFG_IDX_W-1:0] index;
  logic [COORD_WIDTH-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ptf_pose.sv =====
module ptf_pose #(
  parameter int COORD_WIDTH    = ptf_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = ptf_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ptf_pkg::pose_ctl_t                     ctl,
  input  logic signed [2*QUAT_FRAC_BITS+1:0]     qp [ptf_pkg::QP_N],
  input  logic signed [COORD_WIDTH-1:0]          t_in [3],
  input  logic [COORD_WIDTH-2:0]                 clr_above,
  input  logic [COORD_WIDTH-2:0]                 clr_below,
  input  logic signed [COORD_WIDTH-1:0]          floor_h,
  output logic signed [QUAT_FRAC_BITS+2:0]       rot [9],
  output logic signed [COORD_WIDTH-1:0]          trans [3],
  output logic signed [COORD_WIDTH:0]            band_lo,
  output logic signed [COORD_WIDTH:0]            band_hi,
  output logic                                   pose_valid
);
  import ptf_pkg::*;

  localparam int Q  = QUAT_FRAC_BITS;
  localparam int RW = QUAT_FRAC_BITS + 3;
  localparam int EW = 2 * QUAT_FRAC_BITS + 5;
  localparam int BW = COORD_WIDTH + 1;

  localparam logic signed [EW-1:0] ONE  = EW'(1) <<< (2 * Q);
  localparam logic signed [EW-1:0] HALF = EW'(1) <<< (Q - 1);
  localparam logic signed [EW-1:0] RMAX = (EW'(1) <<< (RW - 1)) - EW'(1);
  localparam logic signed [EW-1:0] RMIN = -(EW'(1) <<< (RW - 1));

  logic signed [EW-1:0] ent [9];
  logic signed [EW-1:0] rnd [9];
  logic signed [RW-1:0] rot_next [9];
  logic signed [BW-1:0] lo_raw;
  logic signed [BW-1:0] fl_ext;
  logic signed [BW-1:0] lo_next;
  logic signed [BW-1:0] hi_next;

  always_comb begin
    ent[0] = ONE - ((EW'(qp[QP_YY]) + EW'(qp[QP_ZZ])) <<< 1);
    ent[1] = (EW'(qp[QP_XY]) - EW'(qp[QP_WZ])) <<< 1;
    ent[2] = (EW'(qp[QP_XZ]) + EW'(qp[QP_WY])) <<< 1;
    ent[3] = (EW'(qp[QP_XY]) + EW'(qp[QP_WZ])) <<< 1;
    ent[4] = ONE - ((EW'(qp[QP_XX]) + EW'(qp[QP_ZZ])) <<< 1);
    ent[5] = (EW'(qp[QP_YZ]) - EW'(qp[QP_WX])) <<< 1;
    ent[6] = (EW'(qp[QP_XZ]) - EW'(qp[QP_WY])) <<< 1;
    ent[7] = (EW'(qp[QP_YZ]) + EW'(qp[QP_WX])) <<< 1;
    ent[8] = ONE - ((EW'(qp[QP_XX]) + EW'(qp[QP_YY])) <<< 1);
    for (int i = 0; i < 9; i++) begin
      rnd[i] = (ent[i] + HALF) >>> Q;
      if (rnd[i] > RMAX) begin
        rot_next[i] = RMAX[RW-1:0];
      end else if (rnd[i] < RMIN) begin
        rot_next[i] = RMIN[RW-1:0];
      end else begin
        rot_next[i] = rnd[i][RW-1:0];
      end
    end
  end

  always_comb begin
    lo_raw  = BW'(t_in[2]) - BW'($signed({1'b0, clr_below}));
    fl_ext  = BW'(floor_h);
    lo_next = (lo_raw > fl_ext) ? lo_raw : fl_ext;
    hi_next = BW'(t_in[2]) + BW'($signed({1'b0, clr_above}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_valid <= 1'b0;
    end else if (ctl.load) begin
      pose_valid <= 1'b1;
    end else if (ctl.lost) begin
      pose_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rot     <= rot_next;
      trans   <= t_in;
      band_lo <= lo_next;
      band_hi <= hi_next;
    end
  end

endmodule

// ===== src/ptf_xform.sv =====
module ptf_xform #(
  parameter int COORD_WIDTH    = ptf_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = ptf_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ptf_pkg::xf_ctl_t                    ctl,
  input  logic                                vin,
  input  logic                                raw_in,
  input  logic                                fin_in,
  input  logic signed [COORD_WIDTH-1:0]       p_in [3],
  input  logic signed [QUAT_FRAC_BITS+2:0]    rot [9],
  input  logic signed [COORD_WIDTH-1:0]       trans [3],
  input  logic signed [COORD_WIDTH:0]         band_lo,
  input  logic signed [COORD_WIDTH:0]         band_hi,
  output logic                                v2,
  output logic                                v3,
  output logic signed [COORD_WIDTH+3:0]       m3 [3],
  output logic signed [COORD_WIDTH:0]         lo3,
  output logic signed [COORD_WIDTH:0]         hi3,
  output logic                                raw3,
  output logic                                fin3
);
  import ptf_pkg::*;

  localparam int Q   = QUAT_FRAC_BITS;
  localparam int RW  = QUAT_FRAC_BITS + 3;
  localparam int PRW = RW + COORD_WIDTH;
  localparam int SW  = PRW + 3;
  localparam int MW  = COORD_WIDTH + 4;
  localparam int BW  = COORD_WIDTH + 1;

  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (Q - 1);

  logic signed [PRW-1:0]         prod [9];
  logic signed [COORD_WIDTH-1:0] p2 [3];
  logic signed [COORD_WIDTH-1:0] t2 [3];
  logic signed [BW-1:0]          lo2;
  logic signed [BW-1:0]          hi2;
  logic                          raw2;
  logic                          fin2;
  logic signed [SW-1:0]          sum [3];
  logic signed [MW-1:0]          m_next [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ctl.en2) begin
      v2 <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en2 && vin) begin
      for (int i = 0; i < 9; i++) begin
        prod[i] <= PRW'(rot[i]) * PRW'(p_in[i % 3]);
      end
      p2   <= p_in;
      t2   <= trans;
      lo2  <= band_lo;
      hi2  <= band_hi;
      raw2 <= raw_in;
      fin2 <= fin_in;
    end
  end

  // row sums rounded to whole mm, halves upward
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SW'(prod[3*r]) + SW'(prod[3*r+1]) + SW'(prod[3*r+2])
             + (SW'(t2[r]) <<< Q) + HALF;
      m_next[r] = raw2 ? MW'(p2[r]) : MW'(sum[r] >>> Q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ctl.en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en3 && v2) begin
      m3   <= m_next;
      lo3  <= lo2;
      hi3  <= hi2;
      raw3 <= raw2;
      fin3 <= fin2;
    end
  end

endmodule

// ===== src/ptf_out.sv =====
module ptf_out #(
  parameter int COORD_WIDTH = ptf_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          v3,
  input  logic signed [COORD_WIDTH+3:0] m3 [3],
  input  logic signed [COORD_WIDTH:0]   lo3,
  input  logic signed [COORD_WIDTH:0]   hi3,
  input  logic                          raw3,
  input  logic                          fin3,
  ptf_out_if.source                     results
);
  import ptf_pkg::*;

  localparam int MW = COORD_WIDTH + 4;

  localparam logic signed [MW-1:0] CMAX = (MW'(1) <<< (COORD_WIDTH - 1)) - MW'(1);
  localparam logic signed [MW-1:0] CMIN = -(MW'(1) <<< (COORD_WIDTH - 1));

  logic                          load;
  logic                          emit;
  logic signed [COORD_WIDTH-1:0] c_sat [3];

  assign load = !results.valid || results.ready;
  assign emit = raw3 || ((m3[2] >= MW'(lo3)) && (m3[2] <= MW'(hi3)));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (m3[i] > CMAX) begin
        c_sat[i] = CMAX[COORD_WIDTH-1:0];
      end else if (m3[i] < CMIN) begin
        c_sat[i] = CMIN[COORD_WIDTH-1:0];
      end else begin
        c_sat[i] = m3[i][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= v3 && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load && v3) begin
      results.out_x      <= c_sat[0];
      results.out_y      <= c_sat[1];
      results.out_z      <= c_sat[2];
      results.raw_frame  <= raw3;
      results.out_finite <= fin3;
    end
  end

endmodule

// ===== src/point_transform_height_band_filter.sv =====
// Height band filter with rigid map transform. Pose transactions (mode 1) build a
// rotation from the Q1.QUAT_FRAC_BITS quaternion and set the kept height band; mode 2
// marks the pose lost; point transactions (mode 0) are rotated, translated and kept
// when finite and inside the band, or forwarded raw while no pose is held and
// passthrough is on. One transaction is taken every clock unless the output stalls;
// a point result passes through four register stages (input products, rotation
// multiplies, row sums, band test and saturation). Each pose takes effect for every
// point accepted after it.
// Only the output register's ready applies backpressure; bubbles are squeezed out.
module point_transform_height_band_filter #(
  parameter int COORD_WIDTH    = ptf_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = ptf_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ptf_in_if.sink    items,
  ptf_out_if.source results,
  ptf_cfg_if.sink   cfg
);
  import ptf_pkg::*;

  localparam int QW = QUAT_FRAC_BITS + 1;
  localparam int PW = 2 * QW;
  localparam int RW = QUAT_FRAC_BITS + 3;
  localparam int MW = COORD_WIDTH + 4;
  localparam int BW = COORD_WIDTH + 1;

  logic [COORD_WIDTH-2:0]        clr_above;
  logic [COORD_WIDTH-2:0]        clr_below;
  logic signed [COORD_WIDTH-1:0] floor_h;
  logic                          passthrough;

  logic                          v1;
  logic [MODE_W-1:0]             s1_mode;
  logic signed [COORD_WIDTH-1:0] s1_p [3];
  logic signed [COORD_WIDTH-1:0] s1_t [3];
  logic                          s1_fin;
  logic signed [PW-1:0]          s1_qp [QP_N];

  logic                          en1;
  logic                          en4;
  pose_ctl_t                     pose_ctl;
  xf_ctl_t                       xf_ctl;
  logic                          s2_vin;

  logic signed [RW-1:0]          rot [9];
  logic signed [COORD_WIDTH-1:0] trans [3];
  logic signed [BW-1:0]          band_lo;
  logic signed [BW-1:0]          band_hi;
  logic                          pose_valid;

  logic                          v2;
  logic                          v3;
  logic signed [MW-1:0]          m3 [3];
  logic signed [BW-1:0]          lo3;
  logic signed [BW-1:0]          hi3;
  logic                          raw3;
  logic                          fin3;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_above   <= (COORD_WIDTH-1)'(CLR_ABOVE_RST);
      clr_below   <= (COORD_WIDTH-1)'(CLR_BELOW_RST);
      floor_h     <= COORD_WIDTH'(FLOOR_RST);
      passthrough <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_ABOVE: clr_above   <= cfg.data[COORD_WIDTH-2:0];
        CFG_BELOW: clr_below   <= cfg.data[COORD_WIDTH-2:0];
        CFG_FLOOR: floor_h     <= $signed(cfg.data);
        CFG_PASS:  passthrough <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // backpressure chain, output register first
  assign en4           = !results.valid || results.ready;
  assign xf_ctl.en3    = !v3 || en4;
  assign xf_ctl.en2    = !v2 || xf_ctl.en3;
  assign en1           = !v1 || xf_ctl.en2;
  assign items.ready   = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && items.valid) begin
      s1_mode        <= items.mode;
      s1_fin         <= items.point_finite;
      s1_p[0]        <= items.point_x;
      s1_p[1]        <= items.point_y;
      s1_p[2]        <= items.point_z;
      s1_t[0]        <= items.pose_tx;
      s1_t[1]        <= items.pose_ty;
      s1_t[2]        <= items.pose_tz;
      s1_qp[QP_XX]   <= PW'(items.pose_qx) * PW'(items.pose_qx);
      s1_qp[QP_YY]   <= PW'(items.pose_qy) * PW'(items.pose_qy);
      s1_qp[QP_ZZ]   <= PW'(items.pose_qz) * PW'(items.pose_qz);
      s1_qp[QP_XY]   <= PW'(items.pose_qx) * PW'(items.pose_qy);
      s1_qp[QP_XZ]   <= PW'(items.pose_qx) * PW'(items.pose_qz);
      s1_qp[QP_YZ]   <= PW'(items.pose_qy) * PW'(items.pose_qz);
      s1_qp[QP_WX]   <= PW'(items.pose_qw) * PW'(items.pose_qx);
      s1_qp[QP_WY]   <= PW'(items.pose_qw) * PW'(items.pose_qy);
      s1_qp[QP_WZ]   <= PW'(items.pose_qw) * PW'(items.pose_qz);
    end
  end

  // pose commits as it leaves stage one, so later points see it
  always_comb begin
    pose_ctl.load = 1'b0;
    pose_ctl.lost = 1'b0;
    s2_vin        = 1'b0;
    if (v1 && xf_ctl.en2) begin
      unique case (s1_mode)
        MODE_POINT: s2_vin        = pose_valid ? s1_fin : passthrough;
        MODE_POSE:  pose_ctl.load = 1'b1;
        MODE_LOST:  pose_ctl.lost = 1'b1;
        default: ;
      endcase
    end
  end

  ptf_pose #(
    .COORD_WIDTH    (COORD_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_pose (
    .clk        (clk),
    .rst        (rst),
    .ctl        (pose_ctl),
    .qp         (s1_qp),
    .t_in       (s1_t),
    .clr_above  (clr_above),
    .clr_below  (clr_below),
    .floor_h    (floor_h),
    .rot        (rot),
    .trans      (trans),
    .band_lo    (band_lo),
    .band_hi    (band_hi),
    .pose_valid (pose_valid)
  );

  ptf_xform #(
    .COORD_WIDTH    (COORD_WIDTH),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_xform (
    .clk     (clk),
    .rst     (rst),
    .ctl     (xf_ctl),
    .vin     (s2_vin),
    .raw_in  (!pose_valid),
    .fin_in  (s1_fin),
    .p_in    (s1_p),
    .rot     (rot),
    .trans   (trans),
    .band_lo (band_lo),
    .band_hi (band_hi),
    .v2      (v2),
    .v3      (v3),
    .m3      (m3),
    .lo3     (lo3),
    .hi3     (hi3),
    .raw3    (raw3),
    .fin3    (fin3)
  );

  ptf_out #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .v3      (v3 && en4),
    .m3      (m3),
    .lo3     (lo3),
    .hi3     (hi3),
    .raw3    (raw3),
    .fin3    (fin3),
    .results (results)
  );

endmodule

// ===== src/ptf_checker.sv =====
module ptf_checker #(
  parameter int COORD_WIDTH = ptf_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          items_ready,
  input logic                          results_valid,
  input logic                          results_ready,
  input logic signed [COORD_WIDTH-1:0] results_out_x,
  input logic signed [COORD_WIDTH-1:0] results_out_y,
  input logic signed [COORD_WIDTH-1:0] results_out_z,
  input logic                          results_raw_frame,
  input logic                          results_out_finite
);

  // stalled result transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=> results_valid && $stable(results_out_x)
      && $stable(results_out_y) && $stable(results_out_z)
      && $stable(results_raw_frame) && $stable(results_out_finite))
    else $error("stalled result changed");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !results_valid)
    else $error("result after reset");

  // empty output register means the pipe can take input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !results_valid |-> items_ready)
    else $error("input stalled with empty output");

  a_map_finite: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_raw_frame |-> results_out_finite)
    else $error("transformed point not finite");

endmodule

bind point_transform_height_band_filter ptf_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_ptf_checker (
  .clk                (clk),
  .rst                (rst),
  .items_ready        (items.ready),
  .results_valid      (results.valid),
  .results_ready      (results.ready),
  .results_out_x      (results.out_x),
  .results_out_y      (results.out_y),
  .results_out_z      (results.out_z),
  .results_raw_frame  (results.raw_frame),
  .results_out_finite (results.out_finite)
);

// ===== tb/point_transform_height_band_filter_test.sv =====
`timescale 1ns / 100ps

module point_transform_height_band_filter_test;
  import ptf_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int FRAC        = QUAT_FRAC_BITS_DEF;
  localparam int QW          = FRAC + 1;
  localparam int ROT_W       = FRAC + 3;
  localparam int CLR_W       = CW - 1;
  localparam int COORD_MAX   = (1 << (CW - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (CW - 1));
  localparam int CLR_MAX     = (1 << CLR_W) - 1;
  localparam int QUAT_MAX    = (1 << FRAC) - 1;
  localparam int QUAT_MIN    = -(1 << FRAC);
  localparam int PIPE_DEPTH  = 4;
  localparam int SETTLE      = 2 * PIPE_DEPTH;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 130;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    logic                 fin;
    logic signed [QW-1:0] qw;
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [CW-1:0] tz;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 raw;
    logic                 fin;
  } point_out_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum {CHK_MODEL, CHK_NONE, CHK_KEEP} check_t;

  typedef struct {
    row_kind_t               kind;
    item_t                   item;
    check_t                  chk;
    point_out_t              res;
    logic [CLR_W-1:0]        above;
    logic [CLR_W-1:0]        below;
    logic signed [CW-1:0]    floor_mm;
    logic                    pass;
  } stim_row_t;

  logic clk;
  logic rst;

  ptf_in_if  in_bus ();
  ptf_out_if out_bus ();
  ptf_cfg_if cfg_bus ();

  point_transform_height_band_filter dut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_bus),
    .results (out_bus),
    .cfg     (cfg_bus)
  );

  // filter state and settings as the block should hold them
  longint rot[9];
  longint shift[3];
  longint band_lo;
  longint band_hi;
  bit     have_pose;
  longint clr_above;
  longint clr_below;
  longint floor_lvl;
  bit     pass_raw;

  point_out_t pending_points[$];
  stim_row_t  directed[$];
  int         mismatches;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int urand(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic int srand_mag(int a);
    return int'($urandom_range(2 * a, 0)) - a;
  endfunction

  function automatic void add_row(input stim_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  function automatic longint round_entry(longint v);
    longint q;
    longint top;
    top = (longint'(1) <<< (ROT_W - 1)) - 1;
    q = (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (q > top) return top;
    if (q < -top - 1) return -top - 1;
    return q;
  endfunction

  function automatic logic signed [CW-1:0] sat_coord(longint v);
    if (v > COORD_MAX) return CW'(COORD_MAX);
    if (v < COORD_MIN) return CW'(COORD_MIN);
    return v[CW-1:0];
  endfunction

  // exact row sum, halves rounded up to whole mm
  function automatic longint map_row(input item_t it, input int row);
    longint acc;
    acc = rot[3 * row] * longint'(it.px) + rot[3 * row + 1] * longint'(it.py)
        + rot[3 * row + 2] * longint'(it.pz) + (shift[row] <<< FRAC)
        + (longint'(1) <<< (FRAC - 1));
    return acc >>> FRAC;
  endfunction

  function automatic bit transform_and_band(input item_t it, output point_out_t r);
    longint w, x, y, z, one, lo, mx, my, mz;
    r = '0;
    w = it.qw;
    x = it.qx;
    y = it.qy;
    z = it.qz;
    one = longint'(1) <<< (2 * FRAC);
    case (it.mode)
      MODE_POSE: begin
        rot[0] = round_entry(one - 2 * (y * y + z * z));
        rot[1] = round_entry(2 * (x * y - w * z));
        rot[2] = round_entry(2 * (x * z + w * y));
        rot[3] = round_entry(2 * (x * y + w * z));
        rot[4] = round_entry(one - 2 * (x * x + z * z));
        rot[5] = round_entry(2 * (y * z - w * x));
        rot[6] = round_entry(2 * (x * z - w * y));
        rot[7] = round_entry(2 * (y * z + w * x));
        rot[8] = round_entry(one - 2 * (x * x + y * y));
        shift[0] = it.tx;
        shift[1] = it.ty;
        shift[2] = it.tz;
        lo = shift[2] - clr_below;
        band_lo = (lo > floor_lvl) ? lo : floor_lvl;
        band_hi = shift[2] + clr_above;
        have_pose = 1'b1;
        return 1'b0;
      end
      MODE_LOST: begin
        have_pose = 1'b0;
        return 1'b0;
      end
      MODE_POINT: begin
        if (!have_pose) begin
          if (!pass_raw) return 1'b0;
          r = '{it.px, it.py, it.pz, 1'b1, it.fin};
          return 1'b1;
        end
        if (!it.fin) return 1'b0;
        mz = map_row(it, 2);
        if (mz < band_lo || mz > band_hi) return 1'b0;
        mx = map_row(it, 0);
        my = map_row(it, 1);
        r = '{sat_coord(mx), sat_coord(my), sat_coord(mz), 1'b0, 1'b1};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic stim_row_t pt_row(input int x, input int y, input int z, input bit fin,
                                       input check_t chk, input int ex = 0, input int ey = 0,
                                       input int ez = 0, input bit eraw = 0,
                                       input bit efin = 0);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.item = '0;
    r.item.mode = MODE_POINT;
    r.item.px = CW'(x);
    r.item.py = CW'(y);
    r.item.pz = CW'(z);
    r.item.fin = fin;
    r.chk = chk;
    r.res = '{CW'(ex), CW'(ey), CW'(ez), eraw, efin};
    r.above = '0;
    r.below = '0;
    r.floor_mm = '0;
    r.pass = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t pose_row(input int qw, input int qx, input int qy, input int qz,
                                         input int tx, input int ty, input int tz);
    stim_row_t r;
    r = pt_row(0, 0, 0, 1'b0, CHK_NONE);
    r.item.mode = MODE_POSE;
    r.item.qw = QW'(qw);
    r.item.qx = QW'(qx);
    r.item.qy = QW'(qy);
    r.item.qz = QW'(qz);
    r.item.tx = CW'(tx);
    r.item.ty = CW'(ty);
    r.item.tz = CW'(tz);
    return r;
  endfunction

  function automatic stim_row_t ctl_row(input logic [MODE_W-1:0] m);
    stim_row_t r;
    r = pt_row(0, 0, 0, 1'b0, CHK_NONE);
    r.item.mode = m;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input int above, input int below, input int floor_mm,
                                        input bit pass);
    stim_row_t r;
    r = pt_row(0, 0, 0, 1'b0, CHK_NONE);
    r.kind = ROW_CFG;
    r.above = CLR_W'(above);
    r.below = CLR_W'(below);
    r.floor_mm = CW'(floor_mm);
    r.pass = pass;
    return r;
  endfunction

  function automatic item_t random_item(input bit force_pose);
    item_t it;
    int    pick;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    pick = force_pose ? 0 : urand(0, 99);
    if (pick < 8) begin
      it.mode = MODE_POSE;
      if (urand(0, 3) != 0) begin
        it.qw = QW'(urand(26000, QUAT_MAX));
        it.qx = QW'(srand_mag(7000));
        it.qy = QW'(srand_mag(7000));
        it.qz = QW'(srand_mag(7000));
        it.tx = CW'(srand_mag(30000));
        it.ty = CW'(srand_mag(30000));
        it.tz = CW'(urand(-4000, 12000));
      end
    end else if (pick < 11) begin
      it.mode = MODE_LOST;
    end else if (pick < 13) begin
      it.mode = MODE_UNUSED;
    end else begin
      it.mode = MODE_POINT;
      if (urand(0, 9) < 7) begin
        it.px = CW'(srand_mag(12000));
        it.py = CW'(srand_mag(12000));
        it.pz = CW'(srand_mag(9000));
      end
      it.fin = (urand(0, 9) != 0);
    end
    return it;
  endfunction

  task automatic send_item(input item_t it, input check_t chk, input point_out_t typed);
    point_out_t r;
    bit         kept;
    in_bus.valid        <= 1'b1;
    in_bus.mode         <= it.mode;
    in_bus.point_x      <= it.px;
    in_bus.point_y      <= it.py;
    in_bus.point_z      <= it.pz;
    in_bus.point_finite <= it.fin;
    in_bus.pose_qw      <= it.qw;
    in_bus.pose_qx      <= it.qx;
    in_bus.pose_qy      <= it.qy;
    in_bus.pose_qz      <= it.qz;
    in_bus.pose_tx      <= it.tx;
    in_bus.pose_ty      <= it.ty;
    in_bus.pose_tz      <= it.tz;
    do @(posedge clk); while (!in_bus.ready);
    kept = transform_and_band(it, r);
    case (chk)
      CHK_MODEL: if (kept) pending_points.insert(pending_points.size(), r);
      CHK_KEEP:  pending_points.insert(pending_points.size(), typed);
      default: ;
    endcase
  endtask

  task automatic drain_results(input int extra);
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_settings(input logic [CLR_W-1:0] above, input logic [CLR_W-1:0] below,
                                input logic signed [CW-1:0] floor_mm, input logic pass);
    cfg_idx_t      idx;
    logic [CW-1:0] word;
    for (int k = 0; k < 4; k++) begin
      idx = cfg_idx_t'(k);
      case (idx)
        CFG_ABOVE: word = {1'b0, above};
        CFG_BELOW: word = {1'b0, below};
        CFG_FLOOR: word = floor_mm;
        default:   word = {{(CW - 1){1'b0}}, pass};
      endcase
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx;
      cfg_bus.data  <= word;
      do @(posedge clk); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
    clr_above = above;
    clr_below = below;
    floor_lvl = floor_mm;
    pass_raw  = pass;
  endtask

  // receiver stalls
  initial begin
    int style;
    int left;
    int cyc;
    style = 0;
    left  = 0;
    cyc   = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        style = urand(0, 3);
        left  = urand(50, 400);
      end
      left--;
      cyc++;
      case (style)
        0:       out_bus.ready <= 1'b1;
        1:       out_bus.ready <= (urand(0, 3) != 0);
        2:       out_bus.ready <= (urand(0, 2) == 0);
        default: out_bus.ready <= ((cyc % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    point_out_t got;
    point_out_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      got = {out_bus.out_x, out_bus.out_y, out_bus.out_z, out_bus.raw_frame,
             out_bus.out_finite};
      if (pending_points.size() == 0) begin
        mismatches++;
        $display("%0t: expected none, got x=%0d y=%0d z=%0d raw=%0b finite=%0b", $time,
                 got.x, got.y, got.z, got.raw, got.fin);
      end else begin
        want = pending_points.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected x=%0d y=%0d z=%0d raw=%0b finite=%0b, got x=%0d y=%0d z=%0d raw=%0b finite=%0b",
                   $time, want.x, want.y, want.z, want.raw, want.fin,
                   got.x, got.y, got.z, got.raw, got.fin);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet > QUIET_LIMIT) begin
        $display("point_transform_height_band_filter: mismatch");
        $finish;
      end
    end
  end

  initial begin
    item_t     it;
    int        burst_left;
    int        gap;
    int        gap_max;

    rst                 <= 1'b1;
    in_bus.valid        <= 1'b0;
    in_bus.mode         <= MODE_POINT;
    in_bus.point_x      <= '0;
    in_bus.point_y      <= '0;
    in_bus.point_z      <= '0;
    in_bus.point_finite <= 1'b0;
    in_bus.pose_qw      <= '0;
    in_bus.pose_qx      <= '0;
    in_bus.pose_qy      <= '0;
    in_bus.pose_qz      <= '0;
    in_bus.pose_tx      <= '0;
    in_bus.pose_ty      <= '0;
    in_bus.pose_tz      <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CFG_ABOVE;
    cfg_bus.data        <= '0;
    mismatches = 0;
    have_pose  = 1'b0;
    band_lo    = 0;
    band_hi    = 0;
    clr_above  = CLR_ABOVE_RST;
    clr_below  = CLR_BELOW_RST;
    floor_lvl  = FLOOR_RST;
    pass_raw   = 1'b1;
    foreach (rot[i]) rot[i] = 0;
    foreach (shift[i]) shift[i] = 0;

    // raw passthrough out of reset
    add_row(pt_row(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, CHK_KEEP,
                   COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1));
    add_row(pt_row(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, CHK_KEEP,
                   COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0));
    add_row(ctl_row(MODE_UNUSED));
    // identity pose: band is 1500..6000
    add_row(pose_row(QUAT_MAX, 0, 0, 0, 0, 0, 0));
    add_row(pt_row(100, 200, 3000, 1'b1, CHK_KEEP, 100, 200, 3000, 1'b0, 1'b1));
    add_row(pt_row(0, 0, 1499, 1'b1, CHK_NONE));
    add_row(pt_row(-7, 9, 1500, 1'b1, CHK_KEEP, -7, 9, 1500, 1'b0, 1'b1));
    add_row(pt_row(42, -42, 6000, 1'b1, CHK_KEEP, 42, -42, 6000, 1'b0, 1'b1));
    add_row(pt_row(0, 0, 6001, 1'b1, CHK_NONE));
    add_row(pt_row(0, 0, 3000, 1'b0, CHK_NONE));
    add_row(pose_row(QUAT_MAX, 0, 0, 0, COORD_MAX, COORD_MIN, 0));
    add_row(pt_row(COORD_MAX, COORD_MIN, 3000, 1'b1, CHK_KEEP,
                   COORD_MAX, COORD_MIN, 3000, 1'b0, 1'b1));
    // unnormalised quaternion, entries saturate
    add_row(pose_row(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN, 1000, -2000, 3000));
    add_row(pt_row(1234, -567, 89, 1'b1, CHK_MODEL));
    add_row(pose_row(23170, 0, 0, 23170, 0, 0, 2000));
    add_row(pt_row(1000, 2000, 2500, 1'b1, CHK_MODEL));
    add_row(ctl_row(MODE_LOST));
    add_row(pt_row(5, 6, 7, 1'b1, CHK_KEEP, 5, 6, 7, 1'b1, 1'b1));
    add_row(cfg_row(CLR_ABOVE_RST, CLR_BELOW_RST, FLOOR_RST, 1'b0));
    add_row(pt_row(5, 6, 7, 1'b1, CHK_NONE));
    // floor above the top of the band
    add_row(cfg_row(0, 0, COORD_MAX, 1'b0));
    add_row(pose_row(QUAT_MAX, 0, 0, 0, 0, 0, 0));
    add_row(pt_row(0, 0, 0, 1'b1, CHK_NONE));
    add_row(cfg_row(CLR_MAX, CLR_MAX, COORD_MIN, 1'b1));
    add_row(pose_row(QUAT_MAX, 0, 0, 0, 0, 0, COORD_MAX));
    add_row(pt_row(0, 0, COORD_MAX, 1'b1, CHK_KEEP, 0, 0, COORD_MAX, 1'b0, 1'b1));
    add_row(pose_row(QUAT_MAX, 0, 0, 0, 0, 0, COORD_MIN));
    add_row(pt_row(0, 0, COORD_MIN, 1'b1, CHK_NONE));
    add_row(pt_row(0, 0, 0, 1'b1, CHK_KEEP, 0, 0, COORD_MIN, 1'b0, 1'b1));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain_results(SETTLE);
        write_settings(directed[i].above, directed[i].below, directed[i].floor_mm,
                       directed[i].pass);
      end else begin
        send_item(directed[i].item, directed[i].chk, directed[i].res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results(SETTLE);
      case (p)
        0: write_settings(CLR_W'(urand(2000, 10000)), CLR_W'(urand(1000, 6000)),
                          CW'(srand_mag(3000)), 1'b1);
        1: write_settings('0, '0, CW'(COORD_MIN), 1'b0);
        2: write_settings(CLR_W'(CLR_MAX), CLR_W'(CLR_MAX), CW'(COORD_MAX), 1'b1);
        3: write_settings(CLR_W'(CLR_MAX), CLR_W'(CLR_MAX), CW'(COORD_MIN),
                          1'(urand(0, 1)));
        4: write_settings(CLR_W'($urandom), CLR_W'($urandom), CW'($urandom), 1'($urandom));
        5: write_settings(CLR_W'(urand(500, 8000)), CLR_W'(urand(500, 8000)),
                          CW'(srand_mag(6000)), 1'b0);
        default: write_settings(CLR_W'(urand(2000, 10000)), CLR_W'(urand(1000, 6000)),
                                CW'(srand_mag(3000)), 1'b1);
      endcase
      gap_max = (p % 3 == 1) ? 0 : 8;
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = urand(1, 24);
          gap = urand(0, gap_max);
          if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        if (n == PHASE_ITEMS / 2)
          drain_results(0);
        it = random_item(n == 0 && urand(0, 3) != 0);
        send_item(it, CHK_MODEL, '0);
      end
    end

    drain_results(SETTLE);
    if (mismatches == 0 && pending_points.size() == 0)
      $display("point_transform_height_band_filter: match");
    else
      $display("point_transform_height_band_filter: mismatch");
    $finish;
  end

endmodule
